### hw/rtl/dted_pkg.sv
// Shared types, constants and calendar tables for the date to epoch-day block.
// Used by every module under hw/rtl; no dependencies of its own.
package dted_pkg;

    localparam logic [13:0] EPOCH_YEAR         = 14'd1970;
    localparam logic [12:0] LEAPS_BEFORE_EPOCH = 13'd477;
    localparam logic [22:0] DAYS_PER_YEAR      = 23'd365;
    // floor(x / 25) = (x * RECIP_25) >> Q25_SHIFT, exact for x < 4096
    localparam logic [24:0] RECIP_25           = 25'd5243;
    localparam int unsigned Q25_SHIFT          = 17;
    localparam logic [3:0]  MONTH_FEB          = 4'd2;
    localparam logic [3:0]  MONTH_DEC          = 4'd12;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_YEAR  = 2'd1,
        ST_MONTH = 2'd2,
        ST_DAY   = 2'd3
    } status_t;

    // stage 1 -> stage 2
    typedef struct packed {
        status_t     status;
        logic [5:0]  day;
        logic        year_div4;
        logic [11:0] year_q4;
        logic [7:0]  year_q100;
        logic [13:0] year_off;
        logic [4:0]  month_len;
        logic [8:0]  days_before;
        logic        is_feb;
        logic        after_feb;
    } front_t;

    // stage 2 -> stage 3
    typedef struct packed {
        status_t     status;
        logic [22:0] year_days;
        logic [11:0] extra_days;
    } count_t;

    // stage 3 -> stage 4
    typedef struct packed {
        status_t     status;
        logic [22:0] days;
    } sum_t;

    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/dted_front.sv
// Stage 1: year and month checks, month tables, year/4 and year/100 quotient.
// Depends on dted_pkg.
module dted_front
    import dted_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  day_of_month,
    input  logic [3:0]  month_number,
    input  logic [13:0] year_number,
    output logic        out_valid,
    input  logic        out_ready,
    output front_t      out_data
);

    logic        valid_reg;
    front_t      data_reg;
    front_t      data_next;
    logic [24:0] q25_prod;

    always_comb begin
        q25_prod = {13'd0, year_number[13:2]} * RECIP_25;

        data_next.day         = day_of_month;
        data_next.year_div4   = (year_number[1:0] == 2'd0);
        data_next.year_q4     = year_number[13:2];
        data_next.year_q100   = q25_prod[Q25_SHIFT +: 8];
        data_next.year_off    = year_number - EPOCH_YEAR;
        data_next.month_len   = month_length(month_number);
        data_next.days_before = days_before_month(month_number);
        data_next.is_feb      = (month_number == MONTH_FEB);
        data_next.after_feb   = (month_number > MONTH_FEB);

        if (year_number < EPOCH_YEAR) begin
            data_next.status = ST_YEAR;
        end else if (month_number == 4'd0 || month_number > MONTH_DEC) begin
            data_next.status = ST_MONTH;
        end else begin
            data_next.status = ST_OK;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/dted_count.sv
// Stage 2: leap year, day check, day of year, leap count and year*365.
// Depends on dted_pkg.
module dted_count
    import dted_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output count_t out_data
);

    logic        valid_reg;
    count_t      data_reg;
    count_t      data_next;
    logic [11:0] q100_x25;
    logic        div100;
    logic        leap;
    logic [4:0]  len;
    logic        day_ok;
    logic [8:0]  day_of_year;
    logic [12:0] extra;

    always_comb begin
        q100_x25 = {in_data.year_q100, 4'b0} + {1'b0, in_data.year_q100, 3'b0}
                 + {4'b0, in_data.year_q100};
        div100   = (in_data.year_q4 == q100_x25);
        leap     = in_data.year_div4 && (!div100 || in_data.year_q100[1:0] == 2'd0);
        len      = in_data.month_len + {4'b0, in_data.is_feb && leap};
        day_ok   = (in_data.day != 6'd0) && (in_data.day <= {1'b0, len});

        day_of_year = in_data.days_before + {8'b0, in_data.after_feb && leap}
                    + {3'b0, in_data.day} - 9'd1;

        // leaps in 1..year-1 = q4 - q100 + q400 - leap(year)
        extra = {1'b0, in_data.year_q4} - {5'b0, in_data.year_q100}
              + {7'b0, in_data.year_q100[7:2]} - {12'b0, leap}
              - LEAPS_BEFORE_EPOCH + {4'b0, day_of_year};

        data_next.year_days  = {9'd0, in_data.year_off} * DAYS_PER_YEAR;
        data_next.extra_days = extra[11:0];
        if (in_data.status == ST_OK && !day_ok) begin
            data_next.status = ST_DAY;
        end else begin
            data_next.status = in_data.status;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/dted_sum.sv
// Stage 3: final day count, forced to zero on any error status.
// Depends on dted_pkg.
module dted_sum
    import dted_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  count_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output sum_t   out_data
);

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;

    always_comb begin
        data_next.status = in_data.status;
        if (in_data.status == ST_OK) begin
            data_next.days = in_data.year_days + {11'd0, in_data.extra_days};
        end else begin
            data_next.days = 23'd0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/dted_wday.sv
// Stage 4: weekday as (days + 4) mod 7 by octal digit folding; output register.
// Depends on dted_pkg.
module dted_wday
    import dted_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  sum_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output status_t     out_status,
    output logic [22:0] out_days,
    output logic [2:0]  out_weekday
);

    logic        valid_reg;
    status_t     status_reg;
    logic [22:0] days_reg;
    logic [2:0]  weekday_reg;
    logic [2:0]  weekday_next;
    logic [23:0] shifted;
    logic [5:0]  digit_sum;
    logic [3:0]  fold;

    always_comb begin
        shifted   = {1'b0, in_data.days} + 24'd4;
        digit_sum = 6'd0;
        // 8 = 1 mod 7: sum the octal digits
        for (int i = 0; i < 8; i++) begin
            digit_sum = digit_sum + {3'b0, shifted[3*i +: 3]};
        end
        fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
        if (in_data.status != ST_OK || fold >= 4'd14) begin
            weekday_next = 3'd0;
        end else if (fold >= 4'd7) begin
            weekday_next = 3'(fold - 4'd7);
        end else begin
            weekday_next = fold[2:0];
        end
    end

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_status  = status_reg;
    assign out_days    = days_reg;
    assign out_weekday = weekday_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            status_reg  <= in_data.status;
            days_reg    <= in_data.days;
            weekday_reg <= weekday_next;
        end
    end

endmodule

### hw/rtl/date_to_epoch_day_weekday_unit.sv
// Gregorian date to day count since 1 January 1970 and weekday.
// Pipeline of four registered stages: dted_front, dted_count, dted_sum,
// dted_wday. Depends on dted_pkg.
//
// Input channel (s_): one request per date. tdata holds day_of_month,
// month_number and year_number. Output channel (m_): one result per request,
// in order, with status, days_since_epoch and weekday.
// Status: OK, year before 1970, bad month (0 or 13..15), bad day (0 or past the
// month's length, February 29 days in leap years). On any error the day count
// and weekday are zero; checks run year first, then month, then day.
// m_tvalid rises once a request has passed through to stage 4. Throughput: one
// request per cycle while m_tready is high; the four stage registers
// (leap-count multiply in stage 1, year*365 multiply in stage 2, final add in
// stage 3, mod-7 fold in stage 4) each hold one request.
// Stall: every stage keeps a valid bit and advances when the stage after it is
// empty or moving, so a low m_tready holds results in place and bubbles get
// squeezed out; s_tready drops only when all four stages are full and the
// output is stalled. Nothing is lost or repeated.
// Reset: aresetn low at a clock edge clears all stage valid bits; the data
// registers are not reset, and there is no warm-up after release.
module date_to_epoch_day_weekday_unit
    import dted_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [5:0] day_of_month, [9:6] month_number,
                                   // [23:10] year_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] status, [24:2] days_since_epoch,
                                   // [27:25] weekday, [31:28] zero
);

    logic        v1, r1;
    logic        v2, r2;
    logic        v3, r3;
    front_t      d1;
    count_t      d2;
    sum_t        d3;
    status_t     res_status;
    logic [22:0] res_days;
    logic [2:0]  res_weekday;

    // stage 1: checks on year and month, quotient of year/100
    dted_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .day_of_month (s_tdata[5:0]),
        .month_number (s_tdata[9:6]),
        .year_number  (s_tdata[23:10]),
        .out_valid    (v1),
        .out_ready    (r1),
        .out_data     (d1)
    );

    // stage 2: leap year, day check, leap count, year*365
    dted_count u_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    // stage 3: total day count
    dted_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (d2),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    // stage 4: weekday and output register
    dted_wday u_wday (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v3),
        .in_ready    (r3),
        .in_data     (d3),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (res_status),
        .out_days    (res_days),
        .out_weekday (res_weekday)
    );

    assign m_tdata = {4'd0, res_weekday, res_days, res_status};

`ifndef SYNTHESIS
    // drop input readiness only when the whole pipe is full and stalled
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1 && v2 && v3 && m_tvalid && !m_tready))
        else $error("s_tready low with room in the pipeline");

    // a request leaving stage 1 must show up in stage 2
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1 && r1) |=> v2)
        else $error("stage 1 request lost on its way to stage 2");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status != ST_OK) |-> (res_days == 23'd0 && res_weekday == 3'd0))
        else $error("nonzero result on error status");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_weekday != 3'd7))
        else $error("weekday out of range");
`endif

endmodule

### test/date_to_epoch_day_weekday_unit_checker.sv
// Checker for the date to epoch-day block: watches both stream channels, predicts each result.
// Depends on dted_pkg for status_t; hands the mismatch count and the open-result count to the top.
`timescale 1ns / 1ps

module date_to_epoch_day_weekday_unit_checker
    import dted_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int unsigned fail_count,
    output int unsigned due_count
);

    typedef struct packed {
        status_t     status;
        logic [22:0] days;
        logic [2:0]  wday;
    } epoch_answer_t;

    localparam int unsigned FIRST_YEAR = 1970;

    epoch_answer_t epoch_due_q[$];
    int unsigned   mismatches = 0;

    function automatic int unsigned leap_years_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic epoch_answer_t epoch_day_of(input logic [5:0] d, input logic [3:0] m,
                                                   input logic [13:0] y);
        int unsigned   month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned   yr;
        int unsigned   len;
        int unsigned   count;
        bit            leap;
        epoch_answer_t ans;
        ans = '{status: ST_OK, days: '0, wday: '0};
        yr  = y;
        if (yr < FIRST_YEAR) begin
            ans.status = ST_YEAR;
        end else if (m < 1 || m > 12) begin
            ans.status = ST_MONTH;
        end else begin
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            len  = month_days[m - 1];
            if (m == 2 && leap) len = 29;
            if (d < 1 || d > len) begin
                ans.status = ST_DAY;
            end else begin
                count = (yr - FIRST_YEAR) * 365
                      + leap_years_through(yr - 1) - leap_years_through(FIRST_YEAR - 1);
                // whole months before this one, plus the leap day once past February
                for (int i = 0; i < m - 1; i++) count += month_days[i];
                if (m > 2 && leap) count += 1;
                count += d - 1;
                ans.days = count[22:0];
                ans.wday = 3'((count + 4) % 7);
            end
        end
        return ans;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        epoch_answer_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                epoch_due_q.push_back(epoch_day_of(s_tdata[5:0], s_tdata[9:6], s_tdata[23:10]));
            if (m_tvalid && m_tready) begin
                if (epoch_due_q.size() == 0) begin
                    flag_mismatch("unexpected result, tdata", m_tdata, 0);
                end else begin
                    want = epoch_due_q.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        flag_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[24:2] !== want.days)
                        flag_mismatch("days_since_epoch", m_tdata[24:2], want.days);
                    if (m_tdata[27:25] !== want.wday)
                        flag_mismatch("weekday", m_tdata[27:25], want.wday);
                    if (m_tdata[31:28] !== 4'd0)
                        flag_mismatch("padding", m_tdata[31:28], 0);
                end
            end
        end
        fail_count <= mismatches;
        due_count  <= epoch_due_q.size();
    end

endmodule

### test/date_to_epoch_day_weekday_unit_tb.sv
// Testbench top for date_to_epoch_day_weekday_unit: drives dates, stalls the result side.
// Depends on dted_pkg, the block itself and date_to_epoch_day_weekday_unit_checker.
`timescale 1ns / 1ps

module date_to_epoch_day_weekday_unit_tb;

    localparam int unsigned RANDOM_DATES = 900;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int unsigned fail_count;
    int unsigned due_count;

    // requests left in the current sender burst
    int unsigned burst_left = 0;

    // receiver stall pattern: current mode and cycles left in it
    int unsigned sink_mode = 0;
    int unsigned sink_left = 0;

    always #5 aclk = ~aclk;

    date_to_epoch_day_weekday_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    date_to_epoch_day_weekday_unit_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // Receiver: switch among always ready, random ready and long stalls.
    // Each mode holds for a random stretch so stalls hit every pipeline phase.
    always @(posedge aclk) begin
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(4, 60);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Hold a request until the block takes it. Bursts of random length are
    // separated by random gaps; a gap of zero keeps tvalid high across bursts.
    task automatic send_date(input logic [5:0] d, input logic [3:0] m, input logic [13:0] y);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, m, d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Build one random date: mostly well formed with random content, the rest
    // fully random noise or dates with one field broken on purpose.
    task automatic send_random_date();
        int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // noise: any bit pattern in every field
            send_date(6'($urandom), 4'($urandom), 14'($urandom));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: yr = $urandom_range(1970, 2100);
                4:          yr = 100 * $urandom_range(20, 163);
                5:          yr = 4 * $urandom_range(493, 4095);
                default:    yr = $urandom_range(1970, 16383);
            endcase
            mo  = $urandom_range(1, 12);
            len = month_days[mo - 1];
            if (mo == 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) len = 29;
            case ($urandom_range(0, 9))
                0:       dy = len;
                1:       dy = len + 1;
                default: dy = $urandom_range(1, len);
            endcase
            if (pick >= 90) begin
                // break one field so the error order gets exercised
                case ($urandom_range(0, 2))
                    0:       yr = $urandom_range(0, 1969);
                    1:       mo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
                    default: dy = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 63);
                endcase
            end
            send_date(dy[5:0], mo[3:0], yr[13:0]);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: epoch, leap rules, month and day edges, check order, field extremes
        send_date(6'd1,  4'd1,  14'd1970);
        send_date(6'd31, 4'd12, 14'd1970);
        send_date(6'd1,  4'd3,  14'd1972);
        send_date(6'd29, 4'd2,  14'd1972);
        send_date(6'd29, 4'd2,  14'd1971);
        send_date(6'd29, 4'd2,  14'd2000);
        send_date(6'd29, 4'd2,  14'd2100);
        send_date(6'd28, 4'd2,  14'd2100);
        send_date(6'd30, 4'd2,  14'd2000);
        send_date(6'd31, 4'd4,  14'd2024);
        send_date(6'd30, 4'd4,  14'd2024);
        send_date(6'd0,  4'd5,  14'd2024);
        send_date(6'd63, 4'd1,  14'd2024);
        send_date(6'd1,  4'd0,  14'd2024);
        send_date(6'd1,  4'd13, 14'd2024);
        send_date(6'd15, 4'd15, 14'd2024);
        send_date(6'd1,  4'd1,  14'd1969);
        send_date(6'd0,  4'd0,  14'd0);
        send_date(6'd63, 4'd15, 14'd0);
        send_date(6'd63, 4'd15, 14'd16383);
        send_date(6'd0,  4'd0,  14'd16383);
        send_date(6'd31, 4'd12, 14'd16383);
        send_date(6'd1,  4'd1,  14'd16383);
        send_date(6'd31, 4'd7,  14'd9999);
        send_date(6'd19, 4'd1,  14'd2038);

        repeat (RANDOM_DATES) send_random_date();
        s_tvalid <= 1'b0;

        // drain: let the open count take in the last request, wait for every
        // open result, then keep watching for strays before the verdict
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (fail_count == 0 && due_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dted_pkg.sv
hw/rtl/dted_front.sv
hw/rtl/dted_count.sv
hw/rtl/dted_sum.sv
hw/rtl/dted_wday.sv
hw/rtl/date_to_epoch_day_weekday_unit.sv
test/date_to_epoch_day_weekday_unit_checker.sv
test/date_to_epoch_day_weekday_unit_tb.sv
